// ===== design/assert_macros.svh =====
// Assertion macros shared by the vector normalizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define VN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define VN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/vn_pkg.sv =====
// Shared widths and types for the 3D vector normalizer.
// No dependencies; used by every vn_* module and the top level.
package vn_pkg;

  localparam int CompW  = 32;          // input component width
  localparam int FracW  = 30;          // fraction bits of the result
  localparam int SumW   = 2 * CompW;   // sum of squares
  localparam int RootW  = SumW / 2;    // square root width
  localparam int QuotW  = FracW + 1;   // quotient magnitude, up to 2^FracW
  localparam int OutW   = 32;          // result component width
  localparam int NormSt = 5;           // normalise shifter stages (32,16,8,4,2)

  // Sideband carried alongside the sum of squares
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][CompW-1:0] mag;
    logic                  zero;
  } side_t;

endpackage

// ===== design/vector3_normalize_top.sv =====
// Vector normalizer top level: prep, square root and three dividers.
// Depends on vn_pkg, vn_prep, vn_sqrt, vn_div and assert_macros.svh.
//
// Takes one signed 3-component vector per clock (start_i; busy_o is always
// low) and returns it scaled to unit length in Q1.30, truncated toward zero.
// Each result appears for exactly one cycle with strobe_o; words leave in
// order, one per cycle at most. Between start word and result lie 8 front-end
// stages, the 32-stage square root, the 31-stage dividers and the output
// register. Results cannot be held off, so nothing is buffered. A zero vector
// gives zero components and zero_length_o.
`include "assert_macros.svh"
module vector3_normalize_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [31:0]        vec_x_i,
  input  logic signed [31:0]        vec_y_i,
  input  logic signed [31:0]        vec_z_i,
  output logic                      strobe_o,
  output logic signed [31:0]        unit_x_o,
  output logic signed [31:0]        unit_y_o,
  output logic signed [31:0]        unit_z_o,
  output logic                      zero_length_o
);

  logic                         pre_vld, sq_vld;
  logic [vn_pkg::SumW-1:0]      pre_sum;
  vn_pkg::side_t                pre_side, sq_side;
  logic [vn_pkg::RootW-1:0]     sq_root;
  logic [2:0]                   dv_vld, dv_zero;
  logic [2:0][vn_pkg::OutW-1:0] dv_unit;

  // Fully pipelined, never stalls
  assign busy_o = 1'b0;

  vn_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .vec_x_i (vec_x_i),
    .vec_y_i (vec_y_i),
    .vec_z_i (vec_z_i),
    .valid_o (pre_vld),
    .sum_o   (pre_sum),
    .side_o  (pre_side)
  );

  vn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_vld),
    .sum_i   (pre_sum),
    .side_i  (pre_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // One divider per component
  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld),
      .num_i   (sq_side.mag[i]),
      .len_i   (sq_root),
      .neg_i   (sq_side.neg[i]),
      .zero_i  (sq_side.zero),
      .valid_o (dv_vld[i]),
      .unit_o  (dv_unit[i]),
      .zero_o  (dv_zero[i])
    );
  end

  assign strobe_o      = dv_vld[0];
  assign unit_x_o      = dv_unit[0];
  assign unit_y_o      = dv_unit[1];
  assign unit_z_o      = dv_unit[2];
  assign zero_length_o = dv_zero[0];

  // Lanes stay in lockstep
  `VN_ASSERT(a_lanes, clk_i, rst_ni,
    (dv_vld[0] == dv_vld[1]) && (dv_vld[0] == dv_vld[2]), "divider lanes out of step")

  // A zero-length word carries zero components
  `VN_ASSERT(a_zero_out, clk_i, rst_ni,
    strobe_o && zero_length_o |->
      (unit_x_o == '0) && (unit_y_o == '0) && (unit_z_o == '0), "zero vector not cleared")

endmodule

// ===== design/vn_prep.sv =====
// Front end: magnitudes, squares, sum of squares and even normalising shift.
// Depends on vn_pkg.
module vn_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [vn_pkg::CompW-1:0]  vec_x_i,
  input  logic [vn_pkg::CompW-1:0]  vec_y_i,
  input  logic [vn_pkg::CompW-1:0]  vec_z_i,
  output logic                      valid_o,
  output logic [vn_pkg::SumW-1:0]   sum_o,
  output vn_pkg::side_t             side_o
);

  logic [vn_pkg::CompW-1:0]            comp [3];
  logic                                vld1_q, vld2_q;
  logic [2:0]                          neg1_q, neg2_q;
  logic [2:0][vn_pkg::CompW-1:0]       mag1_q, mag2_q;
  logic [2:0][vn_pkg::SumW-1:0]        sq2_q;
  logic [vn_pkg::SumW-1:0]             sum_d;

  // Shifter pipe; index 0 holds the raw sum
  logic [vn_pkg::NormSt:0]                         nvld_q;
  logic [vn_pkg::NormSt:0][vn_pkg::SumW-1:0]       ns_q;
  vn_pkg::side_t [vn_pkg::NormSt:0]                nsd_q;

  assign comp[0] = vec_x_i;
  assign comp[1] = vec_y_i;
  assign comp[2] = vec_z_i;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      nvld_q[0] <= 1'b0;
    end else begin
      vld1_q    <= valid_i;
      vld2_q    <= vld1_q;
      nvld_q[0] <= vld2_q;
    end
  end

  // Stage 1: sign and magnitude
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      neg1_q[i] <= comp[i][vn_pkg::CompW-1];
      mag1_q[i] <= comp[i][vn_pkg::CompW-1] ? (~comp[i] + 1'b1) : comp[i];
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq2_q[i] <= vn_pkg::SumW'(mag1_q[i]) * vn_pkg::SumW'(mag1_q[i]);
    end
    neg2_q <= neg1_q;
    mag2_q <= mag1_q;
  end

  // Stage 3: sum of squares, zero detect
  assign sum_d = sq2_q[0] + sq2_q[1] + sq2_q[2];

  always_ff @(posedge clk_i) begin
    ns_q[0]      <= sum_d;
    nsd_q[0].neg <= neg2_q;
    nsd_q[0].mag <= mag2_q;
    nsd_q[0].zero <= (sum_d == '0);
  end

  // Stages 4..8: shift the sum left by an even amount, components by half
  for (genvar j = 0; j < vn_pkg::NormSt; j++) begin : g_norm
    localparam int Sh = 32 >> j;
    logic hit;
    assign hit = (ns_q[j][vn_pkg::SumW-1 -: Sh] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nvld_q[j+1] <= 1'b0;
      end else begin
        nvld_q[j+1] <= nvld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      ns_q[j+1]       <= hit ? (ns_q[j] << Sh) : ns_q[j];
      nsd_q[j+1].neg  <= nsd_q[j].neg;
      nsd_q[j+1].zero <= nsd_q[j].zero;
      for (int i = 0; i < 3; i++) begin
        nsd_q[j+1].mag[i] <= hit ? (nsd_q[j].mag[i] << (Sh / 2)) : nsd_q[j].mag[i];
      end
    end
  end

  assign valid_o = nvld_q[vn_pkg::NormSt];
  assign sum_o   = ns_q[vn_pkg::NormSt];
  assign side_o  = nsd_q[vn_pkg::NormSt];

endmodule

// ===== design/vn_sqrt.sv =====
// Pipelined restoring square root, one root bit per stage.
// Depends on vn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vn_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [vn_pkg::SumW-1:0]   sum_i,
  input  vn_pkg::side_t             side_i,
  output logic                      valid_o,
  output logic [vn_pkg::RootW-1:0]  root_o,
  output vn_pkg::side_t             side_o
);

  localparam int N = vn_pkg::RootW;

  logic [N-1:0]                       vld_q;
  logic [N-1:0][vn_pkg::SumW-1:0]     s_q;
  logic [N-1:0][vn_pkg::RootW+1:0]    rem_q;
  logic [N-1:0][vn_pkg::RootW-1:0]    root_q;
  vn_pkg::side_t [N-1:0]              sd_q;

  for (genvar i = 0; i < N; i++) begin : g_st
    logic                       vin;
    logic [vn_pkg::SumW-1:0]    sin;
    logic [vn_pkg::RootW+1:0]   rin, rsh, trial;
    logic [vn_pkg::RootW-1:0]   qin;
    vn_pkg::side_t              sdin;
    logic                       ge;

    if (i == 0) begin : g_first
      assign vin  = valid_i;
      assign sin  = sum_i;
      assign rin  = '0;
      assign qin  = '0;
      assign sdin = side_i;
    end else begin : g_next
      assign vin  = vld_q[i-1];
      assign sin  = s_q[i-1];
      assign rin  = rem_q[i-1];
      assign qin  = root_q[i-1];
      assign sdin = sd_q[i-1];
    end

    // Bring down the next bit pair and try root*4+1
    assign rsh   = {rin[vn_pkg::RootW-1:0], sin[vn_pkg::SumW-1 -: 2]};
    assign trial = {qin, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      s_q[i]    <= sin << 2;
      rem_q[i]  <= ge ? (rsh - trial) : rsh;
      root_q[i] <= {qin[vn_pkg::RootW-2:0], ge};
      sd_q[i]   <= sdin;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = sd_q[N-1];

  // A normalised non-zero sum always gives a root with its top bit set
  `VN_ASSERT(a_root_norm, clk_i, rst_ni,
    valid_o && !side_o.zero |-> root_o[vn_pkg::RootW-1], "root not normalised")

endmodule

// ===== design/vn_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then sign and zero.
// Depends on vn_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [vn_pkg::CompW-1:0]   num_i,
  input  logic [vn_pkg::RootW-1:0]   len_i,
  input  logic                       neg_i,
  input  logic                       zero_i,
  output logic                       valid_o,
  output logic [vn_pkg::OutW-1:0]    unit_o,
  output logic                       zero_o
);

  localparam int N = vn_pkg::QuotW;

  logic [N-1:0]                        vld_q;
  logic [N-1:0][vn_pkg::RootW-1:0]     r_q;
  logic [N-1:0][vn_pkg::RootW-1:0]     len_q;
  logic [N-1:0][vn_pkg::QuotW-1:0]     q_q;
  logic [N-1:0]                        neg_q;
  logic [N-1:0]                        zero_q;
  logic                                vout_q;
  logic [vn_pkg::OutW-1:0]             unit_q;
  logic                                zout_q;
  logic [vn_pkg::OutW-1:0]             qmag;

  for (genvar i = 0; i < N; i++) begin : g_st
    logic                       vin, nin, zin;
    logic [vn_pkg::RootW:0]     rin;
    logic [vn_pkg::RootW-1:0]   lin;
    logic [vn_pkg::QuotW-1:0]   qin;
    logic                       ge;
    logic [vn_pkg::RootW:0]     diff;

    if (i == 0) begin : g_first
      // Numerator never exceeds the length, so the first bit is the 1.0 bit
      assign vin = valid_i;
      assign rin = {1'b0, num_i};
      assign lin = len_i;
      assign qin = '0;
      assign nin = neg_i;
      assign zin = zero_i;
    end else begin : g_next
      assign vin = vld_q[i-1];
      assign rin = {r_q[i-1], 1'b0};
      assign lin = len_q[i-1];
      assign qin = q_q[i-1];
      assign nin = neg_q[i-1];
      assign zin = zero_q[i-1];
    end

    assign ge   = (rin >= {1'b0, lin});
    assign diff = rin - {1'b0, lin};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[i]    <= ge ? diff[vn_pkg::RootW-1:0] : rin[vn_pkg::RootW-1:0];
      len_q[i]  <= lin;
      q_q[i]    <= {qin[vn_pkg::QuotW-2:0], ge};
      neg_q[i]  <= nin;
      zero_q[i] <= zin;
    end
  end

  // Output word: apply sign, force zero for a zero vector
  assign qmag = vn_pkg::OutW'(q_q[N-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    zout_q <= zero_q[N-1];
    if (zero_q[N-1]) begin
      unit_q <= '0;
    end else if (neg_q[N-1]) begin
      unit_q <= ~qmag + 1'b1;
    end else begin
      unit_q <= qmag;
    end
  end

  assign valid_o = vout_q;
  assign unit_o  = unit_q;
  assign zero_o  = zout_q;

  // Quotient magnitude never exceeds 1.0
  `VN_ASSERT(a_q_bound, clk_i, rst_ni,
    vld_q[N-1] && !zero_q[N-1] |->
      (!q_q[N-1][vn_pkg::QuotW-1] || (q_q[N-1][vn_pkg::QuotW-2:0] == '0)),
    "quotient above one")

endmodule
